@@ design/mstw_pkg.sv @@
// ----------------------------------------------------------------------------
// mstw_pkg
// Shared constants, codes and types of the minimum spanning tree weight block.
// ----------------------------------------------------------------------------
`default_nettype none

package mstw_pkg;

   localparam int DEF_MAX_NODES = 64;
   localparam int DEF_MAX_EDGES = 256;
   localparam int WEIGHT_W      = 16;
   localparam int STATUS_W      = 2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_PROC_RD,
      S_PROC_CHK,
      S_FINDA_RD,
      S_FINDA_CHK,
      S_FINDB_RD,
      S_FINDB_CHK,
      S_JOIN,
      S_OUT
   } back_state_type;

   typedef struct packed {
      logic idle;
      logic result_valid;
   } back_status_type;

endpackage

`default_nettype wire

@@ design/mstw_ram.sv @@
// ----------------------------------------------------------------------------
// mstw_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mstw_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/mstw_queue.sv @@
// ----------------------------------------------------------------------------
// mstw_queue
// Two-entry job queue between the load front and the solve back.
// ----------------------------------------------------------------------------
`default_nettype none

module mstw_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  not_empty,
   output logic      [WIDTH-1:0] head
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ design/mstw_front.sv @@
// ----------------------------------------------------------------------------
// mstw_front
// Edge loader: range check, store edges, latch first error, queue a job.
// ----------------------------------------------------------------------------
`default_nettype none

module mstw_front #(
   parameter int MAX_NODES = mstw_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = mstw_pkg::DEF_MAX_EDGES,
   parameter int NODE_W    = $clog2(MAX_NODES),
   parameter int CNT_W     = $clog2(MAX_NODES + 1),
   parameter int FILL_W    = $clog2(MAX_EDGES + 1),
   parameter int ADDR_W    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
   parameter int EDGE_W    = 2 * NODE_W + mstw_pkg::WEIGHT_W,
   parameter int JOB_W     = FILL_W + mstw_pkg::STATUS_W
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            item_valid,
   output logic                                 item_ready,
   input  wire logic [NODE_W-1:0]               src_node,
   input  wire logic [NODE_W-1:0]               dst_node,
   input  wire logic [mstw_pkg::WEIGHT_W-1:0]   edge_weight,
   input  wire logic                            last_edge,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [CNT_W-1:0]                csr_data,
   input  wire mstw_pkg::back_status_type       back_status,
   input  wire logic                            job_pending,
   output logic                                 job_push,
   output logic      [JOB_W-1:0]                job_data,
   output logic                                 edge_wr_en,
   output logic      [ADDR_W-1:0]               edge_wr_addr,
   output logic      [EDGE_W-1:0]               edge_wr_data
);
   import mstw_pkg::*;

   localparam logic [CNT_W-1:0]  NODE_LIMIT = CNT_W'(MAX_NODES);
   localparam logic [FILL_W-1:0] EDGE_LIMIT = FILL_W'(MAX_EDGES);

   logic [CNT_W-1:0]    node_count_ff, node_count_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [STATUS_W-1:0] err_ff, err_in;
   logic                accept, in_range, has_room, store;
   logic [STATUS_W-1:0] item_err, err_now;
   logic [FILL_W-1:0]   fill_now;

   assign csr_ready  = 1'b1;
   // Hold off new edges while a graph waits in the queue or is being solved.
   assign item_ready = back_status.idle && !job_pending;
   assign accept     = item_valid && item_ready;

   always_comb begin
      in_range = (CNT_W'(src_node) < node_count_ff) && (CNT_W'(src_node) < NODE_LIMIT)
              && (CNT_W'(dst_node) < node_count_ff) && (CNT_W'(dst_node) < NODE_LIMIT);
      has_room = (fill_ff < EDGE_LIMIT);
      store    = accept && in_range && has_room;
      item_err = !in_range ? ST_RANGE : (!has_room ? ST_FULL : ST_OK);
      err_now  = (err_ff != ST_OK) ? err_ff : item_err;
      fill_now = fill_ff + FILL_W'(store);

      node_count_in = (csr_valid && csr_ready) ? csr_data : node_count_ff;
      fill_in       = fill_ff;
      err_in        = err_ff;
      if (accept) begin
         fill_in = last_edge ? '0 : fill_now;
         err_in  = last_edge ? ST_OK : err_now;
      end
   end

   assign job_push     = accept && last_edge;
   assign job_data     = {err_now, fill_now};
   assign edge_wr_en   = store;
   assign edge_wr_addr = fill_ff[ADDR_W-1:0];
   assign edge_wr_data = {src_node, dst_node, edge_weight};

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_LIMIT;
         fill_ff       <= '0;
         err_ff        <= ST_OK;
      end else begin
         node_count_ff <= node_count_in;
         fill_ff       <= fill_in;
         err_ff        <= err_in;
      end
   end

endmodule

`default_nettype wire

@@ design/mstw_back.sv @@
// ----------------------------------------------------------------------------
// mstw_back
// Solver: weight-ordered passes over the edge store, disjoint-set walk, result.
// ----------------------------------------------------------------------------
`default_nettype none

module mstw_back #(
   parameter int MAX_NODES = mstw_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = mstw_pkg::DEF_MAX_EDGES,
   parameter int NODE_W    = $clog2(MAX_NODES),
   parameter int FILL_W    = $clog2(MAX_EDGES + 1),
   parameter int ADDR_W    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
   parameter int EDGE_W    = 2 * NODE_W + mstw_pkg::WEIGHT_W,
   parameter int JOB_W     = FILL_W + mstw_pkg::STATUS_W,
   parameter int TOT_W     = mstw_pkg::WEIGHT_W + NODE_W
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          job_valid,
   input  wire logic [JOB_W-1:0]              job_data,
   output logic                               job_pop,
   output logic      [ADDR_W-1:0]             edge_rd_addr,
   input  wire logic [EDGE_W-1:0]             edge_rd_data,
   output mstw_pkg::back_status_type          back_status,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [TOT_W-1:0]              rsp_total,
   output logic      [mstw_pkg::STATUS_W-1:0] rsp_status
);
   import mstw_pkg::*;

   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(MAX_NODES - 1);

   back_state_type         state_ff, state_in;
   logic [FILL_W-1:0]      idx_ff, idx_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic signed [WEIGHT_W-1:0] cur_ff, cur_in, best_ff, best_in, ew_ff, ew_in;
   logic                   have_cur_ff, have_cur_in, found_ff, found_in;
   logic [NODE_W-1:0]      node_ff, node_in, root_a_ff, root_a_in, dst_ff, dst_in;
   logic [TOT_W-1:0]       total_ff, total_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TOT_W-1:0]       rsp_total_ff, rsp_total_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   logic                   par_wr_en;
   logic [NODE_W-1:0]      par_wr_addr, par_wr_data, par_rd_data;

   logic [NODE_W-1:0]      e_src, e_dst;
   logic signed [WEIGHT_W-1:0] e_w;

   assign {e_src, e_dst, e_w} = edge_rd_data;

   mstw_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES), .ADDR_W(NODE_W)) u_parent (
      .clock   (clock),
      .wr_en   (par_wr_en),
      .wr_addr (par_wr_addr),
      .wr_data (par_wr_data),
      .rd_addr (node_ff),
      .rd_data (par_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      fill_in       = fill_ff;
      cur_in        = cur_ff;
      best_in       = best_ff;
      ew_in         = ew_ff;
      have_cur_in   = have_cur_ff;
      found_in      = found_ff;
      node_in       = node_ff;
      root_a_in     = root_a_ff;
      dst_in        = dst_ff;
      total_in      = total_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_total_in  = rsp_total_ff;
      rsp_status_in = rsp_status_ff;
      job_pop       = 1'b0;
      par_wr_en     = 1'b0;
      par_wr_addr   = node_ff;
      par_wr_data   = node_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_pop                = 1'b1;
               {status_in, fill_in}   = job_data;
               total_in               = '0;
               node_in                = '0;
               state_in = (job_data[JOB_W-1 -: STATUS_W] != ST_OK) ? S_OUT : S_INIT;
            end
         end
         S_INIT: begin
            // Point every node at itself.
            par_wr_en = 1'b1;
            node_in   = node_ff + 1'b1;
            if (node_ff == LAST_NODE) begin
               have_cur_in = 1'b0;
               found_in    = 1'b0;
               idx_in      = '0;
               state_in    = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (idx_ff == fill_ff) begin
               idx_in   = '0;
               cur_in   = best_ff;
               have_cur_in = 1'b1;
               state_in = found_ff ? S_PROC_RD : S_OUT;
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            // Smallest weight above the weight just handled.
            if ((!have_cur_ff || e_w > cur_ff) && (!found_ff || e_w < best_ff)) begin
               best_in  = e_w;
               found_in = 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_SCAN_RD;
         end
         S_PROC_RD: begin
            if (idx_ff == fill_ff) begin
               idx_in   = '0;
               found_in = 1'b0;
               state_in = S_SCAN_RD;
            end else begin
               state_in = S_PROC_CHK;
            end
         end
         S_PROC_CHK: begin
            if (e_w == cur_ff) begin
               node_in  = e_src;
               dst_in   = e_dst;
               ew_in    = e_w;
               state_in = S_FINDA_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_PROC_RD;
            end
         end
         S_FINDA_RD: state_in = S_FINDA_CHK;
         S_FINDA_CHK: begin
            if (par_rd_data == node_ff) begin
               root_a_in = node_ff;
               node_in   = dst_ff;
               state_in  = S_FINDB_RD;
            end else begin
               node_in   = par_rd_data;
               state_in  = S_FINDA_RD;
            end
         end
         S_FINDB_RD: state_in = S_FINDB_CHK;
         S_FINDB_CHK: begin
            if (par_rd_data == node_ff) begin
               state_in = S_JOIN;
            end else begin
               node_in  = par_rd_data;
               state_in = S_FINDB_RD;
            end
         end
         S_JOIN: begin
            // Different roots: hang the first tree under the second, count it.
            if (root_a_ff != node_ff) begin
               par_wr_en   = 1'b1;
               par_wr_addr = root_a_ff;
               par_wr_data = node_ff;
               total_in    = total_ff + TOT_W'(ew_ff);
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_PROC_RD;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_total_in  = total_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign edge_rd_addr            = idx_ff[ADDR_W-1:0];
   assign back_status.idle        = (state_ff == S_IDLE);
   assign back_status.result_valid = rsp_valid_ff;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_total               = rsp_total_ff;
   assign rsp_status              = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      fill_ff       <= fill_in;
      cur_ff        <= cur_in;
      best_ff       <= best_in;
      ew_ff         <= ew_in;
      have_cur_ff   <= have_cur_in;
      found_ff      <= found_in;
      node_ff       <= node_in;
      root_a_ff     <= root_a_in;
      dst_ff        <= dst_in;
      total_ff      <= total_in;
      status_ff     <= status_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

`default_nettype wire

@@ design/minimum_spanning_tree_weight.sv @@
// ----------------------------------------------------------------------------
// minimum_spanning_tree_weight
// Loads weighted edges, then returns the minimum spanning forest weight.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                Payload
// req_      in   req_tvalid/req_tready    tdata: src, dst, weight; tlast: last
// rsp_      out  rsp_tvalid/rsp_tready    tdata: total weight; tuser: status
// csr_      in   csr_valid/csr_ready      csr_data: node count
//
// Edges load one per cycle into the edge RAM while the solver is idle and no
// job waits. After the last edge the solver points every node of the parent
// store at itself, then for each distinct weight runs one scan pass over the
// edges and one process pass that, for each edge of that weight, walks both
// ends to their roots and joins differing roots; a last scan pass finds no
// heavier weight and ends the walk. The edge RAM's single read port sets the
// pass length. No new edge transfer is taken until the result is in the
// output register; the output register holds a stalled result without
// blocking the next graph's load. Reset is synchronous; it clears control
// state and sets node count to MAX_NODES.
// ----------------------------------------------------------------------------
`default_nettype none

module minimum_spanning_tree_weight #(
   parameter int MAX_NODES = mstw_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = mstw_pkg::DEF_MAX_EDGES,
   parameter int NODE_W    = $clog2(MAX_NODES),
   parameter int CNT_W     = $clog2(MAX_NODES + 1),
   parameter int IN_W      = ((2 * NODE_W + mstw_pkg::WEIGHT_W + 7) / 8) * 8,
   parameter int TOT_W     = mstw_pkg::WEIGHT_W + NODE_W,
   parameter int OUT_W     = ((TOT_W + 7) / 8) * 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [IN_W-1:0]               req_tdata,  // src_node, dst_node, edge_weight
   input  wire logic                          req_tlast,  // last_edge
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [OUT_W-1:0]              rsp_tdata,  // total_weight
   output logic      [mstw_pkg::STATUS_W-1:0] rsp_tuser,  // status
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CNT_W-1:0]              csr_data
);
   import mstw_pkg::*;

   localparam int FILL_W = $clog2(MAX_EDGES + 1);
   localparam int ADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EDGE_W = 2 * NODE_W + WEIGHT_W;
   localparam int JOB_W  = FILL_W + STATUS_W;

   back_status_type     back_status;
   logic                job_push, job_full, job_pop, job_valid;
   logic [JOB_W-1:0]    job_in, job_head;
   logic                edge_wr_en;
   logic [ADDR_W-1:0]   edge_wr_addr, edge_rd_addr;
   logic [EDGE_W-1:0]   edge_wr_data, edge_rd_data;
   logic [TOT_W-1:0]    rsp_total;

   mstw_front #(
      .MAX_NODES (MAX_NODES), .MAX_EDGES (MAX_EDGES), .NODE_W (NODE_W), .CNT_W (CNT_W),
      .FILL_W (FILL_W), .ADDR_W (ADDR_W), .EDGE_W (EDGE_W), .JOB_W (JOB_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (req_tvalid),
      .item_ready   (req_tready),
      .src_node     (req_tdata[NODE_W-1:0]),
      .dst_node     (req_tdata[2*NODE_W-1:NODE_W]),
      .edge_weight  (req_tdata[EDGE_W-1:2*NODE_W]),
      .last_edge    (req_tlast),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .back_status  (back_status),
      .job_pending  (job_valid || job_full),
      .job_push     (job_push),
      .job_data     (job_in),
      .edge_wr_en   (edge_wr_en),
      .edge_wr_addr (edge_wr_addr),
      .edge_wr_data (edge_wr_data)
   );

   mstw_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES), .ADDR_W(ADDR_W)) u_edges (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (edge_wr_addr),
      .wr_data (edge_wr_data),
      .rd_addr (edge_rd_addr),
      .rd_data (edge_rd_data)
   );

   mstw_queue #(.WIDTH(JOB_W)) u_jobs (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .not_empty (job_valid),
      .head      (job_head)
   );

   mstw_back #(
      .MAX_NODES (MAX_NODES), .MAX_EDGES (MAX_EDGES), .NODE_W (NODE_W), .FILL_W (FILL_W),
      .ADDR_W (ADDR_W), .EDGE_W (EDGE_W), .JOB_W (JOB_W), .TOT_W (TOT_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job_data     (job_head),
      .job_pop      (job_pop),
      .edge_rd_addr (edge_rd_addr),
      .edge_rd_data (edge_rd_data),
      .back_status  (back_status),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_total    (rsp_total),
      .rsp_status   (rsp_tuser)
   );

   // Pad the total up to whole bytes with zeros.
   assign rsp_tdata = OUT_W'(rsp_total);

endmodule

`default_nettype wire

@@ design/mstw_checker.sv @@
// ----------------------------------------------------------------------------
// mstw_checker
// Port-level checks on the minimum spanning tree weight block.
// ----------------------------------------------------------------------------
`default_nettype none

module mstw_checker #(
   parameter int OUT_W = 24,
   parameter int TOT_W = 22
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic                          req_tlast,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [OUT_W-1:0]              rsp_tdata,
   input wire logic [mstw_pkg::STATUS_W-1:0] rsp_tuser
);
   import mstw_pkg::*;

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // A closed graph blocks the next edge transfer.
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("edge taken right after last edge");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK || rsp_tuser == ST_RANGE || rsp_tuser == ST_FULL))
      else $error("bad status code");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata[TOT_W-1:0] == '0)
      else $error("error result carries a weight");

endmodule

bind minimum_spanning_tree_weight mstw_checker #(
   .OUT_W (OUT_W), .TOT_W (TOT_W)
) u_mstw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

@@ tb/sv/minimum_spanning_tree_weight_test.sv @@
// ----------------------------------------------------------------------------
// minimum_spanning_tree_weight_test
// Self-checking bench for the minimum spanning forest weight block.
// Graphs stream in as edge transfers. A behavioural union-find solver predicts
// the forest weight and status of each graph. Results are scoreboarded in
// order. The bench runs through several node counts and idle/stall profiles.
// ----------------------------------------------------------------------------
`default_nettype none

module minimum_spanning_tree_weight_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mstw_pkg::*;

   localparam int NODES      = DEF_MAX_NODES;
   localparam int EDGES      = DEF_MAX_EDGES;
   localparam int CYCLE_CAP  = 3000000;
   localparam int DRAIN_WAIT = 200;

   typedef struct {
      logic signed [21:0]  total;
      logic [STATUS_W-1:0] status;
   } forest_result_t;

   typedef struct {
      bit          is_cfg;
      logic [6:0]  count;
      logic [5:0]  src;
      logic [5:0]  dst;
      logic [15:0] weight;
      bit          last;
      bit          typed;
      int          total;
      logic [STATUS_W-1:0] status;
   } stim_row_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [6:0]  csr_data;

   // shadow of the block: stored edges, first error, node count
   logic [5:0]  graph_src[$];
   logic [5:0]  graph_dst[$];
   logic [15:0] graph_wt[$];
   logic [STATUS_W-1:0] first_fault;
   logic [6:0]  node_limit;

   forest_result_t forest_due[$];
   int fault_count;
   int cycle_count;
   int gap_pct;
   int stall_pct;
   int hold_off;

   minimum_spanning_tree_weight dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // src_node, dst_node, edge_weight
      .req_tlast  (req_tlast),   // last_edge
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // total_weight
      .rsp_tuser  (rsp_tuser),   // status
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Forest weight of the stored graph: sort by weight, then join sets.
   // Tie order and tree shape never change the total, so plain union-find
   // without compression is enough here.
   function automatic int forest_total();
      int order[$];
      int root_of[NODES];
      int n, k, a, b, key, sum;
      sum = 0;
      n = graph_wt.size();
      for (int i = 0; i < NODES; i++) root_of[i] = i;
      for (int i = 0; i < n; i++) order.push_back(i);
      for (int i = 1; i < n; i++) begin
         key = order[i];
         k = i;
         while (k > 0 && $signed(graph_wt[order[k-1]]) > $signed(graph_wt[key])) begin
            order[k] = order[k-1];
            k--;
         end
         order[k] = key;
      end
      for (int i = 0; i < n; i++) begin
         a = graph_src[order[i]];
         b = graph_dst[order[i]];
         while (root_of[a] != a) a = root_of[a];
         while (root_of[b] != b) b = root_of[b];
         if (a != b) begin
            sum += $signed(graph_wt[order[i]]);
            root_of[a] = b;
         end
      end
      return sum;
   endfunction

   // Take one accepted edge into the shadow; return 1 when a result is due.
   function automatic bit absorb_edge(input logic [5:0] s, input logic [5:0] d,
                                      input logic [15:0] w, input bit l,
                                      output forest_result_t res);
      int lim;
      lim = (node_limit > NODES) ? NODES : node_limit;
      if (s >= lim || d >= lim) begin
         if (first_fault == ST_OK) first_fault = ST_RANGE;
      end else if (graph_wt.size() >= EDGES) begin
         if (first_fault == ST_OK) first_fault = ST_FULL;
      end else begin
         graph_src.push_back(s);
         graph_dst.push_back(d);
         graph_wt.push_back(w);
      end
      if (!l) return 0;
      res.status = first_fault;
      res.total  = (first_fault == ST_OK) ? 22'(forest_total()) : '0;
      graph_src.delete();
      graph_dst.delete();
      graph_wt.delete();
      first_fault = ST_OK;
      return 1;
   endfunction

   // Offer one edge from a falling edge; return at the falling edge after the transfer.
   task automatic send_edge(input logic [5:0] s, input logic [5:0] d,
                            input logic [15:0] w, input bit l,
                            input bit typed = 0, input int tw = 0,
                            input logic [STATUS_W-1:0] ts = ST_OK);
      forest_result_t res;
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {4'b0, w, d, s};
      req_tlast  = l;
      do @(posedge clock); while (!req_tready);
      if (absorb_edge(s, d, w, l, res)) begin
         if (typed) begin
            res.total  = 22'(tw);
            res.status = ts;
         end
         forest_due.push_back(res);
      end
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Pause the sender until every expected result is in, then let the solver settle.
   task automatic drain();
      while (forest_due.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_node_count(input logic [6:0] v);
      drain();
      csr_valid = 1'b1;
      csr_data  = v;
      do @(posedge clock); while (!csr_ready);
      node_limit = v;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Random graph. Nodes stay mostly inside the node count; a few stray out.
   task automatic send_graph(input int n_edges, input int wt_span);
      int lim;
      logic [5:0] s, d;
      logic [15:0] w;
      lim = (node_limit > NODES) ? NODES : node_limit;
      for (int i = 0; i < n_edges; i++) begin
         if (lim == 0 || $urandom_range(99) < 6) begin
            s = 6'($urandom_range(63));
            d = 6'($urandom_range(63));
         end else begin
            s = 6'($urandom_range(lim - 1));
            d = 6'($urandom_range(lim - 1));
         end
         if (wt_span == 0) w = 16'($urandom_range(65535));
         else w = 16'($urandom_range(2 * wt_span) - wt_span);
         send_edge(s, d, w, i == n_edges - 1);
      end
   endtask

   // Result sink: random stalls, plus a long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off   <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Scoreboard: compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      forest_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (forest_due.size() == 0) begin
            $error("unexpected result: total_weight %0d status %0d",
                   $signed(rsp_tdata[21:0]), rsp_tuser);
            fault_count++;
         end else begin
            want = forest_due.pop_front();
            if (rsp_tdata[21:0] !== want.total) begin
               $error("total_weight: expected %0d, got %0d", want.total,
                      $signed(rsp_tdata[21:0]));
               fault_count++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               fault_count++;
            end
         end
      end
   end

   stim_row_t plan[$];

   task automatic add_row(input bit c, input logic [6:0] cnt, input logic [5:0] s,
                          input logic [5:0] d, input int w, input bit l,
                          input bit t, input int tw, input logic [STATUS_W-1:0] ts);
      stim_row_t r;
      r.is_cfg = c;  r.count = cnt;  r.src = s;  r.dst = d;
      r.weight = 16'(w);  r.last = l;  r.typed = t;  r.total = tw;  r.status = ts;
      plan.push_back(r);
   endtask

   initial begin
      int graphs, sent, n;
      logic [6:0] counts[6];
      fault_count = 0;
      cycle_count = 0;
      gap_pct     = 0;
      stall_pct   = 0;
      hold_off    = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      node_limit  = 7'd64;
      first_fault = ST_OK;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes, ties, self loop, range faults, register extremes.
      add_row(0, 0, 0, 63, -32768, 1, 1, -32768, ST_OK);
      add_row(0, 0, 63, 0, 32767, 1, 1, 32767, ST_OK);
      add_row(0, 0, 5, 5, 100, 1, 1, 0, ST_OK);
      add_row(0, 0, 1, 2, 10, 0, 0, 0, ST_OK);
      add_row(0, 0, 2, 3, -5, 0, 0, 0, ST_OK);
      add_row(0, 0, 1, 3, 7, 1, 0, 0, ST_OK);
      add_row(0, 0, 0, 1, 3, 0, 0, 0, ST_OK);
      add_row(0, 0, 1, 2, 3, 0, 0, 0, ST_OK);
      add_row(0, 0, 0, 2, 3, 1, 0, 0, ST_OK);
      add_row(1, 4, 0, 0, 0, 0, 0, 0, ST_OK);
      add_row(0, 0, 0, 4, 9, 1, 1, 0, ST_RANGE);
      add_row(0, 0, 4, 0, 9, 0, 0, 0, ST_OK);
      add_row(0, 0, 0, 1, 5, 1, 1, 0, ST_RANGE);
      add_row(1, 0, 0, 0, 0, 0, 0, 0, ST_OK);
      add_row(0, 0, 0, 0, 1, 1, 1, 0, ST_RANGE);
      add_row(1, 127, 0, 0, 0, 0, 0, 0, ST_OK);
      add_row(0, 0, 63, 62, -1, 1, 1, -1, ST_OK);
      foreach (plan[i]) begin
         if (plan[i].is_cfg) write_node_count(plan[i].count);
         else send_edge(plan[i].src, plan[i].dst, plan[i].weight, plan[i].last,
                        plan[i].typed, plan[i].total, plan[i].status);
      end

      // Random graphs across node counts and idle/stall profiles.
      counts = '{7'd64, 7'd127, 7'd1, 7'd0, 7'($urandom_range(2, 63)), 7'd64};
      for (int ph = 0; ph < 6; ph++) begin
         write_node_count(counts[ph]);
         case (ph % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 71; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 71; end
            default: begin gap_pct = 35; stall_pct = 35; end
         endcase
         sent = 0;
         graphs = 0;
         while (sent < 30) begin
            // early on: hold the sink off while edges keep arriving
            if (graphs == 1 && ph == 2) hold_off = 400;
            // and once let everything drain before the next graph
            if (graphs == 2) drain();
            n = $urandom_range(1, 9);
            send_graph(n, ($urandom_range(2) == 0) ? 4 : 0);
            sent += n;
            graphs++;
         end
      end

      // Large graphs: a full store with few distinct weights, then overflow.
      write_node_count(7'd64);
      gap_pct = 0;
      stall_pct = 20;
      send_graph(EDGES, 3);
      send_graph(EDGES + 3, 3);

      drain();
      if (fault_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
